[hw/rtl/spq_pkg.sv]
package spq_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 8;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 7;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENQUEUE   = 2'd0,
		ACT_DEQUEUE   = 2'd1,
		ACT_REMOVE_EQ = 2'd2,
		ACT_REMOVE_GE = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic              insert_mode;
		logic [PRIO_W-1:0] key;
		logic [DATA_W-1:0] new_data;
	} cell_ctrl_t;

endpackage

[hw/rtl/spq_cell.sv]
module spq_cell (
	input  logic                       clk,
	input  spq_pkg::cell_ctrl_t        ctrl,
	input  logic                       ins_en,
	input  logic                       rem_en,
	input  logic                       valid,
	input  logic                       prev_flag,
	input  logic [spq_pkg::DATA_W-1:0] prev_data,
	input  logic [spq_pkg::PRIO_W-1:0] prev_prio,
	input  logic [spq_pkg::DATA_W-1:0] next_data,
	input  logic [spq_pkg::PRIO_W-1:0] next_prio,
	output logic                       flag,
	output logic                       first,
	output logic                       eq,
	output logic [spq_pkg::DATA_W-1:0] data,
	output logic [spq_pkg::PRIO_W-1:0] prio
);
	import spq_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic [PRIO_W-1:0] prio_q;

	// insert: cell lies at or past the insertion point
	// remove: cell lies at or past the first entry not below the key
	always_comb begin
		if (ctrl.insert_mode) begin
			flag = !valid || (prio_q > ctrl.key);
		end else begin
			flag = valid && (prio_q >= ctrl.key);
		end
		first = flag && !prev_flag;
		eq    = valid && (prio_q == ctrl.key);
	end

	always_ff @(posedge clk) begin
		if (ins_en && flag) begin
			if (prev_flag) begin
				data_q <= prev_data;
				prio_q <= prev_prio;
			end else begin
				data_q <= ctrl.new_data;
				prio_q <= ctrl.key;
			end
		end else if (rem_en && flag) begin
			data_q <= next_data;
			prio_q <= next_prio;
		end
	end

	assign data = data_q;
	assign prio = prio_q;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// sorted priority queue with keyed removal
// holds up to CAPACITY words of 32-bit data and 8-bit priority, kept in a row
// of cells sorted by ascending priority; equal priorities keep arrival order
// command channel: a word is taken at a rising edge with start high and busy
// low; action picks enqueue, dequeue head, remove first equal priority, or
// remove first priority at least the key given on priority_req
// every word is compared in all cells at once and the row shifts by one place
// in the same cycle, so busy stays low and one word is taken each cycle
// result channel: one result per word, shown for one cycle with done high,
// the cycle after the word is taken (throughput 1 per cycle)
// the result carries the removed data and priority (zero if none), status
// and the occupancy after the action
// the receiver cannot stall; a result not taken in its cycle is gone
// reset clears the occupancy count and done only; the cell contents are unknown
// until written and are never read beyond the count
module sorted_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [spq_pkg::ACT_W-1:0]         action,
	input  logic signed [spq_pkg::DATA_W-1:0] item_data,
	input  logic [spq_pkg::PRIO_W-1:0]        priority_req,
	output logic                              done,
	output logic signed [spq_pkg::DATA_W-1:0] removed_data,
	output logic [spq_pkg::PRIO_W-1:0]        removed_priority,
	output logic [spq_pkg::STAT_W-1:0]        status,
	output logic [spq_pkg::OCC_W-1:0]         occupancy
);
	import spq_pkg::*;

	cell_ctrl_t        ctrl;
	logic              ins_en;
	logic              rem_en;
	action_t           act;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic              found;
	status_t           stat;
	logic [DATA_W-1:0] sel_data;
	logic [PRIO_W-1:0] sel_prio;
	logic              any_first;
	logic              any_first_eq;
	logic [OCC_W+CNT_W-1:0] occ_wide;

	logic [CAPACITY-1:0] valid;
	logic [CAPACITY-1:0] flag;
	logic [CAPACITY-1:0] first;
	logic [CAPACITY-1:0] eq;
	logic [DATA_W-1:0]   cell_data [CAPACITY];
	logic [PRIO_W-1:0]   cell_prio [CAPACITY];

	logic              done_q;
	logic [DATA_W-1:0] rdata_q;
	logic [PRIO_W-1:0] rprio_q;
	status_t           stat_q;
	logic [OCC_W-1:0]  occ_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign act      = action_t'(action);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(CAPACITY));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic              pflag;
		logic [DATA_W-1:0] pdata;
		logic [PRIO_W-1:0] pprio;
		logic [DATA_W-1:0] ndata;
		logic [PRIO_W-1:0] nprio;

		assign valid[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign pflag = 1'b0;
			assign pdata = cell_data[i];
			assign pprio = cell_prio[i];
		end else begin : g_body
			assign pflag = flag[i-1];
			assign pdata = cell_data[i-1];
			assign pprio = cell_prio[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign ndata = cell_data[i];
			assign nprio = cell_prio[i];
		end else begin : g_inner
			assign ndata = cell_data[i+1];
			assign nprio = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.ins_en    (ins_en),
			.rem_en    (rem_en),
			.valid     (valid[i]),
			.prev_flag (pflag),
			.prev_data (pdata),
			.prev_prio (pprio),
			.next_data (ndata),
			.next_prio (nprio),
			.flag      (flag[i]),
			.first     (first[i]),
			.eq        (eq[i]),
			.data      (cell_data[i]),
			.prio      (cell_prio[i])
		);
	end

	// pick the removal candidate
	always_comb begin
		sel_data = '0;
		sel_prio = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				sel_data = sel_data | cell_data[i];
				sel_prio = sel_prio | cell_prio[i];
			end
		end
	end

	assign any_first    = |first;
	assign any_first_eq = |(first & eq);

	always_comb begin
		ctrl.insert_mode = (act == ACT_ENQUEUE);
		ctrl.key         = (act == ACT_DEQUEUE) ? '0 : priority_req;
		ctrl.new_data    = item_data;
	end

	always_comb begin
		found = 1'b0;
		stat  = ST_DONE;
		unique case (act)
			ACT_ENQUEUE: begin
				stat = is_full ? ST_FULL : ST_DONE;
			end
			ACT_DEQUEUE, ACT_REMOVE_GE: begin
				found = !is_empty && any_first;
				stat  = is_empty ? ST_EMPTY : (found ? ST_DONE : ST_NOMATCH);
			end
			ACT_REMOVE_EQ: begin
				found = !is_empty && any_first_eq;
				stat  = is_empty ? ST_EMPTY : (found ? ST_DONE : ST_NOMATCH);
			end
			default: begin
				stat = ST_DONE;
			end
		endcase
		ins_en = accept && (act == ACT_ENQUEUE) && !is_full;
		rem_en = accept && found;
	end

	always_comb begin
		count_nxt = count_q;
		if (ins_en) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (rem_en) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_q <= rem_en ? sel_data : '0;
			rprio_q <= rem_en ? sel_prio : '0;
			stat_q  <= stat;
			occ_q   <= occ_wide[OCC_W-1:0];
		end
	end

	assign done             = done_q;
	assign removed_data     = rdata_q;
	assign removed_priority = rprio_q;
	assign status           = stat_q;
	assign occupancy        = occ_q;

endmodule
